### design/pffla_pkg.sv
package pffla_pkg;

    localparam int MAX_PAGES_DEF  = 65536;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_RANGE = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [1:0] CFG_KERNEL_END  = 2'd0;
    localparam logic [1:0] CFG_KERNEL_BASE = 2'd1;
    localparam logic [1:0] CFG_MEMORY_TOP  = 2'd2;

    localparam logic [31:0] KERNEL_END_RST  = 32'h0000_0000;
    localparam logic [31:0] KERNEL_BASE_RST = 32'h8000_0000;
    localparam logic [28:0] MEMORY_TOP_RST  = 29'h0E00_0000;

endpackage

### design/page_frame_free_list_allocator.sv
// LIFO page frame allocator. A request is taken when start is high and busy
// is low; its result appears on page_addr and status for exactly one cycle
// with done high, and the receiver cannot stall it. A no-op, or an allocate
// on an empty list, gives its result in the cycle after the request and
// leaves busy low. An allocate with pages on the list holds busy in S_POP
// while the successor link is read from the link memory, and its result is
// registered out of S_POP. A single free holds busy in S_FREE and reports
// from there. A range free pushes one page per cycle through the single
// write port of the link memory, and holds busy until it finds the range end
// or a bad page, reporting the cycle after. The link memory is not reset
// or cleared; only links of pushed pages are ever read.
module page_frame_free_list_allocator #(
    parameter int MAX_PAGES  = pffla_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = pffla_pkg::PAGE_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] start_addr,
    input  logic [31:0] end_addr,
    output logic        done,
    output logic [31:0] page_addr,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int PW = $clog2(MAX_PAGES);
    localparam logic [32:0] PAGE_BYTES = 33'(1) << PAGE_SHIFT;
    localparam logic [32:0] PAGE_MASK  = PAGE_BYTES - 33'(1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_FREE  = 2'd2;
    localparam logic [1:0] S_RANGE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic          head_valid_reg, head_valid_next;
    logic [PW-1:0] head_page_reg, head_page_next;
    logic          done_reg, done_next;
    logic [31:0]   page_addr_reg, page_addr_next;
    logic [1:0]    status_reg, status_next;
    logic [32:0]   p_reg, p_next;
    logic [31:0]   end_reg, end_next;

    logic [31:0]   kernel_end_reg;
    logic [31:0]   kernel_base_reg;
    logic [28:0]   memory_top_reg;

    logic          mem_we;
    logic          mem_re;
    logic [PW:0]   mem_rdata;
    logic          chk_bad;
    logic [PW-1:0] chk_page;
    logic          range_more;
    logic          accept;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign page_addr  = page_addr_reg;
    assign status     = status_reg;
    assign range_more = ({1'b0, p_reg} + {1'b0, PAGE_BYTES}) <= {2'b00, end_reg};

    pffla_page_chk #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .PW         (PW)
    ) u_page_chk (
        .vaddr       (p_reg),
        .kernel_end  (kernel_end_reg),
        .kernel_base (kernel_base_reg),
        .memory_top  (memory_top_reg),
        .bad         (chk_bad),
        .page        (chk_page)
    );

    // Writes happen only in the push states and reads are issued only from
    // idle, so a read never meets a write to the same entry.
    pffla_link_mem #(
        .DEPTH (MAX_PAGES),
        .AW    (PW),
        .DW    (PW + 1)
    ) u_link_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (chk_page),
        .wdata ({head_valid_reg, head_page_reg}),
        .re    (mem_re),
        .raddr (head_page_reg),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        head_page_next  = head_page_reg;
        done_next       = 1'b0;
        page_addr_next  = 32'd0;
        status_next     = pffla_pkg::ST_OK;
        p_next          = p_reg;
        end_next        = end_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        pffla_pkg::ACT_ALLOC:
                        begin
                            if (head_valid_reg)
                            begin
                                mem_re     = 1'b1;
                                state_next = S_POP;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = pffla_pkg::ST_EMPTY;
                            end
                        end
                        pffla_pkg::ACT_FREE:
                        begin
                            p_next     = {1'b0, start_addr};
                            state_next = S_FREE;
                        end
                        pffla_pkg::ACT_RANGE:
                        begin
                            p_next     = ({1'b0, start_addr} + PAGE_MASK) & ~PAGE_MASK;
                            end_next   = end_addr;
                            state_next = S_RANGE;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next       = 1'b1;
                page_addr_next  = (32'(head_page_reg) << PAGE_SHIFT) + kernel_base_reg;
                head_valid_next = mem_rdata[PW];
                head_page_next  = mem_rdata[PW] ? mem_rdata[PW-1:0] : '0;
                state_next      = S_IDLE;
            end
            S_FREE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (chk_bad)
                begin
                    status_next = pffla_pkg::ST_BAD;
                end
                else
                begin
                    mem_we          = 1'b1;
                    head_valid_next = 1'b1;
                    head_page_next  = chk_page;
                end
            end
            S_RANGE:
            begin
                if (!range_more)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (chk_bad)
                begin
                    done_next   = 1'b1;
                    status_next = pffla_pkg::ST_BAD;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    head_valid_next = 1'b1;
                    head_page_next  = chk_page;
                    p_next          = p_reg + PAGE_BYTES;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_valid_reg <= 1'b0;
            head_page_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            head_page_reg  <= head_page_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_addr_reg <= page_addr_next;
        status_reg    <= status_next;
        p_reg         <= p_next;
        end_reg       <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg  <= pffla_pkg::KERNEL_END_RST;
            kernel_base_reg <= pffla_pkg::KERNEL_BASE_RST;
            memory_top_reg  <= pffla_pkg::MEMORY_TOP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pffla_pkg::CFG_KERNEL_END:  kernel_end_reg  <= cfg_data;
                pffla_pkg::CFG_KERNEL_BASE: kernel_base_reg <= cfg_data;
                pffla_pkg::CFG_MEMORY_TOP:  memory_top_reg  <= cfg_data[28:0];
                default:                    ;
            endcase
        end
    end

endmodule

### design/pffla_link_mem.sv
module pffla_link_mem #(
    parameter int DEPTH = pffla_pkg::MAX_PAGES_DEF,
    parameter int AW    = $clog2(pffla_pkg::MAX_PAGES_DEF),
    parameter int DW    = $clog2(pffla_pkg::MAX_PAGES_DEF) + 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/pffla_page_chk.sv
module pffla_page_chk #(
    parameter int MAX_PAGES  = pffla_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = pffla_pkg::PAGE_SHIFT_DEF,
    parameter int PW         = $clog2(pffla_pkg::MAX_PAGES_DEF)
) (
    input  logic [32:0]   vaddr,
    input  logic [31:0]   kernel_end,
    input  logic [31:0]   kernel_base,
    input  logic [28:0]   memory_top,
    output logic          bad,
    output logic [PW-1:0] page
);

    logic [31:0] vaddr_lo;
    logic [31:0] phys;
    logic [31:0] page_full;
    logic        misaligned;

    assign vaddr_lo   = vaddr[31:0];
    assign phys       = vaddr_lo - kernel_base;
    assign page_full  = phys >> PAGE_SHIFT;
    assign misaligned = (vaddr[PAGE_SHIFT-1:0] != '0);
    assign page       = page_full[PW-1:0];

    // Addresses past the 32-bit space, misaligned ones, kernel-image pages and
    // pages outside managed memory or the link table are all rejected.
    assign bad = vaddr[32] || misaligned || (vaddr_lo < kernel_end) ||
                 (phys >= {3'b000, memory_top}) || (page_full >= 32'(MAX_PAGES));

endmodule

### design/pffla_chk.sv
module pffla_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  action,
    input logic        done,
    input logic [31:0] page_addr,
    input logic [1:0]  status
);

    logic accept;

    assign accept = start && !busy;

    // Only a successful allocate carries an address.
    a_addr_zero_on_fail : assert property (@(posedge clk) disable iff (!rst_n)
        done && status != pffla_pkg::ST_OK |-> page_addr == 32'd0)
        else $error("nonzero page_addr on a failed request");

    a_nop_result : assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == pffla_pkg::ACT_NOP |=>
        done && !busy && status == pffla_pkg::ST_OK && page_addr == 32'd0)
        else $error("no-op request did not report at once");

    a_free_timing : assert property (@(posedge clk) disable iff (!rst_n)
        accept && action == pffla_pkg::ACT_FREE |=>
        busy && !done ##1 done && !busy && status != pffla_pkg::ST_EMPTY)
        else $error("single free did not report two cycles after the request");

    a_empty_only_alloc : assert property (@(posedge clk) disable iff (!rst_n)
        accept && action != pffla_pkg::ACT_ALLOC |=> !(done && status == pffla_pkg::ST_EMPTY))
        else $error("empty status on a request that is not an allocate");

endmodule

bind page_frame_free_list_allocator pffla_chk u_pffla_chk (.*);
